[rtl/core/pps_pkg.sv]
package pps_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int OP_W          = 2;
  localparam int BURST_W       = 8;
  localparam int ARR_W         = 16;
  localparam int PRIO_W        = 8;
  localparam int TIDX_W        = 4;
  localparam int TIME_W        = 24;
  localparam int SUM_W         = 32;
  localparam int ENTRY_W       = BURST_W + ARR_W + PRIO_W;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic clear;
    logic nop;
    logic scan_start;
    logic scan_issue;
    logic exec;
    logic acc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    scan_end;
    logic    out_busy;
  } sts_t;

endpackage

[rtl/core/pps_ram.sv]
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/pps_ctrl.sv]
module pps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pps_pkg::sts_t sts,
  output pps_pkg::cmd_t cmd
);
  import pps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_EXEC,
    S_ACC,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.opcode)
          OP_LOAD: begin
            cmd.load  = 1'b1;
            state_nxt = S_RESULT;
          end
          OP_TICK: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
          OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_RESULT;
          end
          default: begin
            cmd.nop   = 1'b1;
            state_nxt = S_RESULT;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = S_EXEC;
        end else begin
          cmd.scan_issue = 1'b1;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[rtl/core/pps_dp.sv]
module pps_dp #(
  parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pps_pkg::cmd_t                cmd,
  output pps_pkg::sts_t                sts,
  input  logic [pps_pkg::OP_W-1:0]     in_opcode,
  input  logic [pps_pkg::BURST_W-1:0]  in_burst,
  input  logic [pps_pkg::ARR_W-1:0]    in_arrival,
  input  logic [pps_pkg::PRIO_W-1:0]   in_priority_req,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_ran,
  output logic [pps_pkg::TIDX_W-1:0]   out_task_index,
  output logic                         out_finished,
  output logic [pps_pkg::TIME_W-1:0]   out_finish_time,
  output logic [pps_pkg::TIME_W-1:0]   out_wait_time,
  output logic [pps_pkg::TIME_W-1:0]   out_turnaround,
  output logic                         out_all_done,
  output logic [pps_pkg::SUM_W-1:0]    out_total_wait,
  output logic [pps_pkg::SUM_W-1:0]    out_total_turnaround,
  output logic                         out_error
);
  import pps_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic [OP_W-1:0]    op_r;
  logic [BURST_W-1:0] burst_r;
  logic [ARR_W-1:0]   arr_r;
  logic [PRIO_W-1:0]  prio_r;

  logic [CNT_W-1:0]  task_cnt_r, done_cnt_r;
  logic [TIME_W-1:0] time_r;
  logic [SUM_W-1:0]  wsum_r, tsum_r;

  logic [CNT_W-1:0]   scan_idx_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               found_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [PRIO_W-1:0]  best_pr_r;
  logic [BURST_W-1:0] best_rem_r, best_burst_r;
  logic [ARR_W-1:0]   best_arr_r;

  logic              res_ran_r, res_fin_r, res_err_r;
  logic [TIDX_W-1:0] res_idx_r;
  logic [TIME_W-1:0] res_ft_r, res_wt_r, res_tat_r;

  logic              out_valid_r, out_ran_r, out_fin_r, out_done_r, out_err_r;
  logic [TIDX_W-1:0] out_idx_r;
  logic [TIME_W-1:0] out_ft_r, out_wt_r, out_tat_r;
  logic [SUM_W-1:0]  out_tw_r, out_tt_r;

  logic               full;
  logic               tsk_we, rem_we;
  logic [IDX_W-1:0]   waddr;
  logic [BURST_W-1:0] rem_wdata;
  logic [ENTRY_W-1:0] tsk_rdata;
  logic [BURST_W-1:0] rem_rdata;
  logic [BURST_W-1:0] rd_burst;
  logic [ARR_W-1:0]   rd_arr;
  logic [PRIO_W-1:0]  rd_pr;
  logic               hit;
  logic [IDX_W+TIDX_W-1:0] load_ext, best_ext;
  logic [TIME_W-1:0]  fin, used, wt, tat;
  logic               fin_now;
  logic [SUM_W:0]     wsum_add, tsum_add;

  assign full     = (task_cnt_r == CNT_W'(MAX_TASKS));
  assign tsk_we   = cmd.load && !full;
  assign rem_we   = tsk_we || (cmd.exec && found_r);
  assign waddr    = cmd.load ? task_cnt_r[IDX_W-1:0] : best_idx_r;
  assign rem_wdata = cmd.load ? burst_r : best_rem_r - BURST_W'(1);

  pps_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TASKS)) u_tsk_ram (
    .clk   (clk),
    .we    (tsk_we),
    .waddr (waddr),
    .wdata ({burst_r, arr_r, prio_r}),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (tsk_rdata)
  );

  pps_ram #(.WIDTH(BURST_W), .DEPTH(MAX_TASKS)) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (waddr),
    .wdata (rem_wdata),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (rem_rdata)
  );

  assign rd_burst = tsk_rdata[ENTRY_W-1 -: BURST_W];
  assign rd_arr   = tsk_rdata[PRIO_W +: ARR_W];
  assign rd_pr    = tsk_rdata[PRIO_W-1:0];

  assign hit = rd_vld_r && ({{(TIME_W-ARR_W){1'b0}}, rd_arr} <= time_r) &&
               (rem_rdata != '0) && (!found_r || (rd_pr < best_pr_r));

  assign load_ext = {{TIDX_W{1'b0}}, task_cnt_r[IDX_W-1:0]};
  assign best_ext = {{TIDX_W{1'b0}}, best_idx_r};

  assign fin     = (time_r == '1) ? time_r : time_r + TIME_W'(1);
  assign used    = TIME_W'(best_burst_r) + TIME_W'(best_arr_r);
  assign wt      = (fin > used) ? fin - used : '0;
  assign tat     = (fin > TIME_W'(best_arr_r)) ? fin - TIME_W'(best_arr_r) : '0;
  assign fin_now = found_r && (best_rem_r == BURST_W'(1));

  assign wsum_add = {1'b0, wsum_r} + (SUM_W+1)'(res_wt_r);
  assign tsum_add = {1'b0, tsum_r} + (SUM_W+1)'(res_tat_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_opcode;
      burst_r <= in_burst;
      arr_r   <= in_arrival;
      prio_r  <= in_priority_req;
    end
    rd_idx_r <= scan_idx_r[IDX_W-1:0];
    if (hit) begin
      best_idx_r   <= rd_idx_r;
      best_pr_r    <= rd_pr;
      best_rem_r   <= rem_rdata;
      best_burst_r <= rd_burst;
      best_arr_r   <= rd_arr;
    end
    if (cmd.load) begin
      res_ran_r <= 1'b0;
      res_fin_r <= 1'b0;
      res_ft_r  <= '0;
      res_wt_r  <= '0;
      res_tat_r <= '0;
      res_err_r <= full;
      res_idx_r <= full ? '0 : load_ext[TIDX_W-1:0];
    end else if (cmd.clear || cmd.nop) begin
      res_ran_r <= 1'b0;
      res_fin_r <= 1'b0;
      res_ft_r  <= '0;
      res_wt_r  <= '0;
      res_tat_r <= '0;
      res_err_r <= 1'b0;
      res_idx_r <= '0;
    end else if (cmd.exec) begin
      res_ran_r <= found_r;
      res_idx_r <= found_r ? best_ext[TIDX_W-1:0] : '0;
      res_fin_r <= fin_now;
      res_ft_r  <= fin_now ? fin : '0;
      res_wt_r  <= fin_now ? wt : '0;
      res_tat_r <= fin_now ? tat : '0;
      res_err_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_ran_r  <= res_ran_r;
      out_idx_r  <= res_idx_r;
      out_fin_r  <= res_fin_r;
      out_ft_r   <= res_ft_r;
      out_wt_r   <= res_wt_r;
      out_tat_r  <= res_tat_r;
      out_done_r <= (done_cnt_r == task_cnt_r);
      out_tw_r   <= wsum_r;
      out_tt_r   <= tsum_r;
      out_err_r  <= res_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_cnt_r  <= '0;
      done_cnt_r  <= '0;
      time_r      <= '0;
      wsum_r      <= '0;
      tsum_r      <= '0;
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_issue;
      if (cmd.scan_start) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end else begin
        if (cmd.scan_issue) begin
          scan_idx_r <= scan_idx_r + CNT_W'(1);
        end
        if (hit) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.clear) begin
        task_cnt_r <= '0;
        done_cnt_r <= '0;
        time_r     <= '0;
        wsum_r     <= '0;
        tsum_r     <= '0;
      end
      if (tsk_we) begin
        task_cnt_r <= task_cnt_r + CNT_W'(1);
        if (burst_r == '0) begin
          done_cnt_r <= done_cnt_r + CNT_W'(1);
        end
      end
      if (cmd.exec) begin
        if (fin_now) begin
          done_cnt_r <= done_cnt_r + CNT_W'(1);
        end
        if (time_r != '1) begin
          time_r <= time_r + TIME_W'(1);
        end
      end
      if (cmd.acc && res_fin_r) begin
        wsum_r <= wsum_add[SUM_W] ? '1 : wsum_add[SUM_W-1:0];
        tsum_r <= tsum_add[SUM_W] ? '1 : tsum_add[SUM_W-1:0];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.opcode   = opcode_t'(op_r);
  assign sts.scan_end = (scan_idx_r == task_cnt_r);
  assign sts.out_busy = out_valid_r && out_stall;

  assign out_valid            = out_valid_r;
  assign out_ran              = out_ran_r;
  assign out_task_index       = out_idx_r;
  assign out_finished         = out_fin_r;
  assign out_finish_time      = out_ft_r;
  assign out_wait_time        = out_wt_r;
  assign out_turnaround       = out_tat_r;
  assign out_all_done         = out_done_r;
  assign out_total_wait       = out_tw_r;
  assign out_total_turnaround = out_tt_r;
  assign out_error            = out_err_r;

endmodule

[rtl/core/preemptive_priority_scheduler_top.sv]
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  opcode, burst, arrival, priority_req
// out_      output     out_valid/out_stall  ran .. error, one item per input item
//
// Load, clear and no-op items write the result register in the decode state.
// A tick item has the task memory read port scan one entry per cycle; then
// the exec state updates the chosen task and the acc state the totals.
// Reset (rst_n low, synchronous) empties the table, zeroes time and totals.
// in_stall is high from accept until the result enters the output register;
// a result held by out_stall blocks only the next result, not its accept.
module preemptive_priority_scheduler_top #(
  parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pps_pkg::OP_W-1:0]     in_opcode,
  input  logic [pps_pkg::BURST_W-1:0]  in_burst,
  input  logic [pps_pkg::ARR_W-1:0]    in_arrival,
  input  logic [pps_pkg::PRIO_W-1:0]   in_priority_req,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_ran,
  output logic [pps_pkg::TIDX_W-1:0]   out_task_index,
  output logic                         out_finished,
  output logic [pps_pkg::TIME_W-1:0]   out_finish_time,
  output logic [pps_pkg::TIME_W-1:0]   out_wait_time,
  output logic [pps_pkg::TIME_W-1:0]   out_turnaround,
  output logic                         out_all_done,
  output logic [pps_pkg::SUM_W-1:0]    out_total_wait,
  output logic [pps_pkg::SUM_W-1:0]    out_total_turnaround,
  output logic                         out_error
);
  import pps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pps_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_opcode            (in_opcode),
    .in_burst             (in_burst),
    .in_arrival           (in_arrival),
    .in_priority_req      (in_priority_req),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_ran              (out_ran),
    .out_task_index       (out_task_index),
    .out_finished         (out_finished),
    .out_finish_time      (out_finish_time),
    .out_wait_time        (out_wait_time),
    .out_turnaround       (out_turnaround),
    .out_all_done         (out_all_done),
    .out_total_wait       (out_total_wait),
    .out_total_turnaround (out_total_turnaround),
    .out_error            (out_error)
  );

endmodule

[tb/sv/pps_schedule_checker.sv]
`timescale 1ns / 1ps
module pps_schedule_checker
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [BURST_W-1:0] in_burst,
  input  logic [ARR_W-1:0]   in_arrival,
  input  logic [PRIO_W-1:0]  in_priority_req,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_ran,
  input  logic [TIDX_W-1:0]  out_task_index,
  input  logic               out_finished,
  input  logic [TIME_W-1:0]  out_finish_time,
  input  logic [TIME_W-1:0]  out_wait_time,
  input  logic [TIME_W-1:0]  out_turnaround,
  input  logic               out_all_done,
  input  logic [SUM_W-1:0]   out_total_wait,
  input  logic [SUM_W-1:0]   out_total_turnaround,
  input  logic               out_error,
  output int                 mismatch_count,
  output int                 pending_count
);

  localparam logic [TIME_W-1:0] TIME_LIMIT = '1;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic              ran;
    logic [TIDX_W-1:0] task_index;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] wait_time;
    logic [TIME_W-1:0] turnaround;
    logic              all_done;
    logic [SUM_W-1:0]  total_wait;
    logic [SUM_W-1:0]  total_turnaround;
    logic              error;
  } sched_report_t;

  logic [BURST_W-1:0] burst_mem   [MAX_TASKS];
  logic [ARR_W-1:0]   arrival_mem [MAX_TASKS];
  logic [PRIO_W-1:0]  prio_mem    [MAX_TASKS];
  logic [BURST_W-1:0] left_mem    [MAX_TASKS];
  int                 loaded;
  int                 completed;
  logic [TIME_W-1:0]  now;
  logic [SUM_W-1:0]   wait_total;
  logic [SUM_W-1:0]   tat_total;
  sched_report_t      queued_reports[$];
  int                 errors = 0;
  int                 waiting = 0;

  assign mismatch_count = errors;
  assign pending_count  = waiting;

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  function automatic sched_report_t schedule_step(opcode_t op, logic [BURST_W-1:0] burst,
                                                  logic [ARR_W-1:0] arrival,
                                                  logic [PRIO_W-1:0] prio);
    sched_report_t rep;
    int pick;
    logic [TIME_W-1:0] fin;
    logic [TIME_W-1:0] used;
    logic [TIME_W-1:0] arr;
    rep = '{default: '0};
    case (op)
      OP_LOAD: begin
        if (loaded >= MAX_TASKS) begin
          rep.error = 1'b1;
        end else begin
          burst_mem[loaded]   = burst;
          arrival_mem[loaded] = arrival;
          prio_mem[loaded]    = prio;
          left_mem[loaded]    = burst;
          rep.task_index      = loaded[TIDX_W-1:0];
          if (burst == '0) completed++;
          loaded++;
        end
      end
      OP_TICK: begin
        pick = -1;
        for (int i = 0; i < loaded; i++) begin
          if (TIME_W'(arrival_mem[i]) <= now && left_mem[i] != '0 &&
              (pick < 0 || prio_mem[i] < prio_mem[pick])) pick = i;
        end
        if (pick >= 0) begin
          rep.ran        = 1'b1;
          rep.task_index = pick[TIDX_W-1:0];
          left_mem[pick] = left_mem[pick] - 1'b1;
          if (left_mem[pick] == '0) begin
            fin  = (now == TIME_LIMIT) ? TIME_LIMIT : now + 1'b1;
            arr  = TIME_W'(arrival_mem[pick]);
            used = TIME_W'(burst_mem[pick]) + arr;
            rep.finished    = 1'b1;
            rep.finish_time = fin;
            rep.wait_time   = (fin > used) ? fin - used : '0;
            rep.turnaround  = (fin > arr) ? fin - arr : '0;
            wait_total = sat_sum(wait_total, SUM_W'(rep.wait_time));
            tat_total  = sat_sum(tat_total, SUM_W'(rep.turnaround));
            completed++;
          end
        end
        if (now != TIME_LIMIT) now = now + 1'b1;
      end
      OP_CLEAR: begin
        loaded     = 0;
        completed  = 0;
        now        = '0;
        wait_total = '0;
        tat_total  = '0;
      end
      default: ;
    endcase
    rep.all_done         = (completed == loaded);
    rep.total_wait       = wait_total;
    rep.total_turnaround = tat_total;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [SUM_W-1:0] want,
                                      logic [SUM_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    sched_report_t want;
    if (!rst_n) begin
      loaded     = 0;
      completed  = 0;
      now        = '0;
      wait_total = '0;
      tat_total  = '0;
      queued_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (queued_reports.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) $display("result item with no input item outstanding");
        end else begin
          want = queued_reports.pop_front();
          check_field("ran", SUM_W'(want.ran), SUM_W'(out_ran));
          check_field("task_index", SUM_W'(want.task_index), SUM_W'(out_task_index));
          check_field("finished", SUM_W'(want.finished), SUM_W'(out_finished));
          check_field("finish_time", SUM_W'(want.finish_time), SUM_W'(out_finish_time));
          check_field("wait_time", SUM_W'(want.wait_time), SUM_W'(out_wait_time));
          check_field("turnaround", SUM_W'(want.turnaround), SUM_W'(out_turnaround));
          check_field("all_done", SUM_W'(want.all_done), SUM_W'(out_all_done));
          check_field("total_wait", want.total_wait, out_total_wait);
          check_field("total_turnaround", want.total_turnaround, out_total_turnaround);
          check_field("error", SUM_W'(want.error), SUM_W'(out_error));
        end
      end
      if (in_valid && !in_stall)
        queued_reports.push_back(schedule_step(opcode_t'(in_opcode), in_burst, in_arrival,
                                               in_priority_req));
    end
    waiting = queued_reports.size();
  end

endmodule

[tb/sv/preemptive_priority_scheduler_top_tb.sv]
`timescale 1ns / 1ps
module preemptive_priority_scheduler_top_tb;
  import pps_pkg::*;

  localparam int ITEM_TARGET = 1050;
  localparam int DRAIN_CYCLES = 40;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_opcode = OP_NOP;
  logic [BURST_W-1:0]   in_burst = '0;
  logic [ARR_W-1:0]     in_arrival = '0;
  logic [PRIO_W-1:0]    in_priority_req = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_ran;
  logic [TIDX_W-1:0]    out_task_index;
  logic                 out_finished;
  logic [TIME_W-1:0]    out_finish_time;
  logic [TIME_W-1:0]    out_wait_time;
  logic [TIME_W-1:0]    out_turnaround;
  logic                 out_all_done;
  logic [SUM_W-1:0]     out_total_wait;
  logic [SUM_W-1:0]     out_total_turnaround;
  logic                 out_error;
  int                   mismatch_count;
  int                   pending_count;

  int                   issued = 0;
  bit                   steady_sender = 1'b0;
  int                   stall_run = 0;

  preemptive_priority_scheduler_top dut (.*);

  pps_schedule_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run = stall_run - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b1;
      stall_run = gap_len();
    end
  end

  task automatic send(opcode_t op, logic [BURST_W-1:0] b, logic [ARR_W-1:0] a,
                      logic [PRIO_W-1:0] p);
    int gap;
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_burst        <= b;
    in_arrival      <= a;
    in_priority_req <= p;
    do @(posedge clk); while (in_stall);
    if (op != OP_NOP) issued++;
    gap = steady_sender ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_noise(opcode_t op);
    send(op, BURST_W'($urandom), ARR_W'($urandom), PRIO_W'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic load_random(output int work);
    logic [BURST_W-1:0] b;
    logic [ARR_W-1:0]   a;
    logic [PRIO_W-1:0]  p;
    b = ($urandom_range(0, 7) == 0) ? BURST_W'($urandom) : BURST_W'($urandom_range(0, 5));
    a = ($urandom_range(0, 7) == 0) ? ARR_W'($urandom) : ARR_W'($urandom_range(0, 8));
    p = ($urandom_range(0, 3) == 0) ? PRIO_W'($urandom) : PRIO_W'($urandom_range(0, 3));
    work = (b > 6) ? 6 : int'(b);
    send(OP_LOAD, b, a, p);
  endtask

  initial begin
    int nload;
    int nticks;
    int work;
    int w;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(OP_TICK, 8'h00, 16'h0000, 8'h00);
    send(OP_NOP, 8'hFF, 16'hFFFF, 8'hFF);
    send(OP_LOAD, 8'd0, 16'd0, 8'd0);
    send(OP_LOAD, 8'd255, 16'hFFFF, 8'd255);
    send(OP_LOAD, 8'd2, 16'd0, 8'd9);
    send(OP_LOAD, 8'd1, 16'd0, 8'd9);
    send(OP_LOAD, 8'd1, 16'd1, 8'd4);
    repeat (6) send(OP_TICK, 8'hFF, 16'hFFFF, 8'hFF);
    send(OP_CLEAR, 8'hFF, 16'hFFFF, 8'hFF);
    send(OP_TICK, 8'h00, 16'h0000, 8'h00);
    send(OP_LOAD, 8'd1, 16'd2, 8'd0);
    repeat (4) send(OP_TICK, 8'h00, 16'h0000, 8'h00);
    drain();

    while (issued < ITEM_TARGET) begin
      steady_sender = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) send_noise(OP_CLEAR);
      nload = ($urandom_range(0, 6) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 5);
      work = 0;
      repeat (nload) begin
        load_random(w);
        work += w;
        if ($urandom_range(0, 4) == 0) send_noise(OP_TICK);
      end
      nticks = work + $urandom_range(0, 10);
      if (nticks > 60) nticks = 60;
      repeat (nticks) begin
        case ($urandom_range(0, 11))
          0: send_noise(OP_NOP);
          1: load_random(w);
          default: send_noise(OP_TICK);
        endcase
      end
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("preemptive_priority_scheduler_top regression: pass");
    end else begin
      $display("preemptive_priority_scheduler_top regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("preemptive_priority_scheduler_top regression: fail");
    $finish;
  end

endmodule
